>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Include this header by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SPG_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/spg_pkg.sv
// Types and constants of the stepper pulse generator.
// Used by the input stage, core, result stage and top level; depends on nothing.
`default_nettype none
package spg_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] SEL_MOVE   = 3'd0;
    localparam logic [2:0] SEL_PPR    = 3'd1;
    localparam logic [2:0] SEL_STATUS = 3'd2;
    localparam logic [2:0] SEL_PERIOD = 3'd3;
    localparam logic [2:0] SEL_MACRO  = 3'd4;

    localparam logic [1:0] CFG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] CFG_ON_TICKS     = 2'd1;
    localparam logic [1:0] CFG_OFF_TICKS    = 2'd2;

    localparam logic [15:0] PPR_DEFAULT     = 16'd100;
    localparam logic [7:0]  PERIOD_DEFAULT  = 8'd100;
    localparam logic [15:0] PERIOD_MIN      = 16'd50;
    localparam logic [15:0] PERIOD_MAX      = 16'd250;
    localparam logic [16:0] HOME_PULSES_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  reg_select;
        logic [15:0] write_value;
        logic        home_sense;
    } in_item_t;

    typedef struct packed {
        logic        step_level;
        logic        direction;
        logic [15:0] read_data;
        logic        error_code;
        logic        homing_active;
        logic        moving;
    } result_t;

    typedef struct packed {
        logic       active_level;
        logic [6:0] on_ticks;
        logic [6:0] off_ticks;
    } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/spg_in_stage.sv
// Input register of the stepper pulse generator.
// Depends on spg_pkg for the item type.
`default_nettype none
module spg_in_stage import spg_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/spg_core.sv
// Motion state and per-item update of the stepper pulse generator.
// Depends on spg_pkg for item, result and configuration types.
`default_nettype none
module spg_core import spg_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     fire,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output result_t       result
);

    logic [14:0] rem_reg, rem_next;
    logic [7:0]  phase_reg, phase_next;
    logic [7:0]  div_reg, div_next;
    logic [7:0]  period_reg, period_next;
    logic [15:0] ppr_reg, ppr_next;
    logic        homing_reg, homing_next;
    logic        want_reg, want_next;
    logic        hdir_reg, hdir_next;
    logic [16:0] hp_reg, hp_next;
    logic        step_reg, step_next;
    logic        dir_reg, dir_next;
    logic [15:0] rd;
    logic        err;
    logic [7:0]  bound;
    logic [7:0]  on_ext;

    assign bound  = {1'b0, cfg.on_ticks} + {1'b0, cfg.off_ticks};
    assign on_ext = {1'b0, cfg.on_ticks};

    always_comb begin
        rem_next    = rem_reg;
        phase_next  = phase_reg;
        div_next    = div_reg;
        period_next = period_reg;
        ppr_next    = ppr_reg;
        homing_next = homing_reg;
        want_next   = want_reg;
        hdir_next   = hdir_reg;
        hp_next     = hp_reg;
        step_next   = step_reg;
        dir_next    = dir_reg;
        rd          = '0;
        err         = 1'b0;
        case (item.command)
            CMD_TICK: begin
                if (div_reg >= period_reg) begin
                    div_next = '0;
                    if (homing_reg) begin
                        homing_next = item.home_sense ^ want_reg;
                        dir_next    = hdir_reg;
                        rem_next    = 15'd1;
                        if (!homing_next) begin
                            hp_next = '0;
                        end
                    end
                    if (hp_next > {1'b0, ppr_reg}) begin
                        homing_next = 1'b0;
                        hp_next     = '0;
                    end
                    if (rem_next != '0) begin
                        if (phase_next <= on_ext) begin
                            step_next  = !cfg.active_level;
                            phase_next = phase_next + 8'd1;
                        end
                        if (phase_next > on_ext && phase_next < bound) begin
                            step_next  = cfg.active_level;
                            phase_next = phase_next + 8'd1;
                        end
                        if (phase_next >= bound) begin
                            phase_next = '0;
                            rem_next   = rem_next - 15'd1;
                            if (homing_next && hp_next < HOME_PULSES_MAX) begin
                                hp_next = hp_next + 17'd1;
                            end
                            step_next = cfg.active_level;
                        end
                    end
                end else begin
                    div_next = div_reg + 8'd1;
                end
            end
            CMD_WRITE: begin
                case (item.reg_select)
                    SEL_MOVE: begin
                        rem_next = item.write_value[14:0];
                        dir_next = item.write_value[15];
                    end
                    SEL_PPR: begin
                        ppr_next = (item.write_value == '0) ? PPR_DEFAULT : item.write_value;
                    end
                    SEL_PERIOD: begin
                        if (item.write_value < PERIOD_MIN) begin
                            period_next = PERIOD_MIN[7:0];
                        end else if (item.write_value > PERIOD_MAX) begin
                            period_next = PERIOD_MAX[7:0];
                        end else begin
                            period_next = item.write_value[7:0];
                        end
                    end
                    SEL_MACRO: begin
                        homing_next = item.write_value[0];
                        want_next   = item.write_value[1];
                        hdir_next   = item.write_value[2];
                        hp_next     = '0;
                    end
                    default: begin
                        err = 1'b1;
                    end
                endcase
            end
            CMD_READ: begin
                case (item.reg_select)
                    SEL_MOVE:   rd = {1'b0, rem_reg};
                    SEL_PPR:    rd = ppr_reg;
                    SEL_STATUS: rd = {15'd0, !(item.home_sense ^ cfg.active_level)};
                    SEL_PERIOD: rd = {8'd0, period_reg};
                    default:    err = 1'b1;
                endcase
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    always_comb begin
        result.step_level    = step_next;
        result.direction     = dir_next;
        result.read_data     = rd;
        result.error_code    = err;
        result.homing_active = homing_next;
        result.moving        = (rem_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg    <= '0;
            phase_reg  <= '0;
            div_reg    <= '0;
            period_reg <= PERIOD_DEFAULT;
            ppr_reg    <= PPR_DEFAULT;
            homing_reg <= 1'b0;
            want_reg   <= 1'b0;
            hdir_reg   <= 1'b0;
            hp_reg     <= '0;
            step_reg   <= 1'b0;
            dir_reg    <= 1'b0;
        end else if (fire) begin
            rem_reg    <= rem_next;
            phase_reg  <= phase_next;
            div_reg    <= div_next;
            period_reg <= period_next;
            ppr_reg    <= ppr_next;
            homing_reg <= homing_next;
            want_reg   <= want_next;
            hdir_reg   <= hdir_next;
            hp_reg     <= hp_next;
            step_reg   <= step_next;
            dir_reg    <= dir_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/spg_out_stage.sv
// Result register of the stepper pulse generator.
// Depends on spg_pkg for the result type.
`default_nettype none
module spg_out_stage import spg_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t result,
    output logic         can_load,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg;
    result_t result_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/stepper_pulse_generator_with_homing.sv
// Stepper step/direction pulse generator with homing, top level.
// Items wait in the input register, results in the result register.
// One item per cycle while the result is not stalled by m_ready. Throughput is
// set by the state update in the core between the input and result registers.
// Synchronous active-low reset returns all state and configuration to defaults.
`default_nettype none
module stepper_pulse_generator_with_homing import spg_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [2:0]  s_reg_select,
    input  wire logic [15:0] s_write_value,
    input  wire logic        s_home_sense,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_step_level,
    output logic             m_direction,
    output logic [15:0]      m_read_data,
    output logic             m_error_code,
    output logic             m_homing_active,
    output logic             m_moving
);

    cfg_t     cfg_reg;
    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     fire;
    result_t  result;
    result_t  m_result;

    assign s_item.command     = s_command;
    assign s_item.reg_select  = s_reg_select;
    assign s_item.write_value = s_write_value;
    assign s_item.home_sense  = s_home_sense;
    assign fire               = item_valid && can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_level <= 1'b1;
            cfg_reg.on_ticks     <= 7'd4;
            cfg_reg.off_ticks    <= 7'd8;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ACTIVE_LEVEL: cfg_reg.active_level <= cfg_wdata[0];
                CFG_ON_TICKS:     cfg_reg.on_ticks     <= cfg_wdata;
                CFG_OFF_TICKS:    cfg_reg.off_ticks    <= cfg_wdata;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    spg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    spg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    spg_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_step_level    = m_result.step_level;
    assign m_direction     = m_result.direction;
    assign m_read_data     = m_result.read_data;
    assign m_error_code    = m_result.error_code;
    assign m_homing_active = m_result.homing_active;
    assign m_moving        = m_result.moving;

endmodule
`default_nettype wire

>>> hw/rtl/spg_checker.sv
// Port-level checks of the stepper pulse generator, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module spg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_read_data,
    input wire logic        m_error_code
);

    `SPG_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `SPG_ASSERT_RST(a_error_no_data, aclk, aresetn, m_valid && m_error_code |-> m_read_data == 16'd0, "error item carries read data")
    `SPG_ASSERT_RST(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_read_data), "stalled result changed")

endmodule

bind stepper_pulse_generator_with_homing spg_checker u_spg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_error_code (m_error_code)
);
`default_nettype wire
